// ===== rtl/core/xfpp_pkg.sv =====
// shared constants for the header/id/length/xor-checksum frame parser
// store geometry, register indexes, phase and kind codes
// no dependencies
package xfpp_pkg;

    // frame store geometry
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam int MAX_RUN     = 60;

    // configuration register indexes
    localparam logic [2:0] REG_HEADER = 3'd0;
    localparam logic [2:0] REG_MODE   = 3'd1;
    localparam logic [2:0] REG_IMU    = 3'd2;
    localparam logic [2:0] REG_AHRS   = 3'd3;
    localparam logic [2:0] REG_INS    = 3'd4;

    // parser phase codes
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_ID      = 2'd1;
    localparam logic [1:0] PH_COLLECT = 2'd2;

    // packet kind codes
    localparam logic [1:0] KIND_IMU     = 2'd0;
    localparam logic [1:0] KIND_AHRS    = 2'd1;
    localparam logic [1:0] KIND_INS     = 2'd2;
    localparam logic [1:0] KIND_UNKNOWN = 2'd3;

endpackage

// ===== rtl/core/xor_framed_packet_parser_top.sv =====
// frame parser top level: byte input, frame store, sequencer and result output
// depends on xfpp_pkg
//
// operation: a byte that closes no frame passes through S_PROC and back to S_IDLE; a frame
//   check walks the store byte by byte, and a resync search and shift each walk it
//   too, all through the one store read port
// flow: one item at a time, input is taken only in S_IDLE; each result waits for m_axis_tready
// reset: i_rst_n synchronous active low, clears control state and counters and loads the
//   configuration defaults; the payload registers and the frame store are not cleared
module xor_framed_packet_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [7:0] out_byte, [13:8] byte_index,
                                        // [45:14] valid_total, [77:46] error_total
    output logic [2:0]  m_axis_tuser,   // [1:0] packet_kind, [2] is_error
    output logic        m_axis_tlast
);

    localparam int FW = xfpp_pkg::FILL_W;
    localparam int AW = xfpp_pkg::ADDR_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PROC   = 4'd1;
    localparam logic [3:0] S_RS_RD  = 4'd2;
    localparam logic [3:0] S_RS_CMP = 4'd3;
    localparam logic [3:0] S_SH_RD  = 4'd4;
    localparam logic [3:0] S_SH_WR  = 4'd5;
    localparam logic [3:0] S_RS_END = 4'd6;
    localparam logic [3:0] S_CK_RD  = 4'd7;
    localparam logic [3:0] S_CK_ACC = 4'd8;
    localparam logic [3:0] S_CK_END = 4'd9;
    localparam logic [3:0] S_EM_RD  = 4'd10;
    localparam logic [3:0] S_EM_LD  = 4'd11;
    localparam logic [3:0] S_EM_WT  = 4'd12;
    localparam logic [3:0] S_ER_WT  = 4'd13;
    localparam logic [3:0] S_RS_RET = 4'd14;

    // configuration registers
    logic [7:0] r_hdr;
    logic       r_il;
    logic [5:0] r_imu, r_ahrs, r_ins;

    // control and datapath registers
    logic [3:0]    r_state, n_state;
    logic [1:0]    r_phase, n_phase;
    logic [FW-1:0] r_fill, n_fill;
    logic [5:0]    r_exp, n_exp;
    logic [1:0]    r_kind, n_kind;
    logic [31:0]   r_good, n_good;
    logic [31:0]   r_bad, n_bad;
    logic [7:0]    r_byte, n_byte;
    logic [FW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_pos, n_pos;
    logic [FW-1:0] r_keep, n_keep;
    logic [7:0]    r_id, n_id;
    logic [7:0]    r_xor, n_xor;
    logic          r_hok, n_hok;
    logic          r_ret, n_ret;
    logic [5:0]    r_n, n_n;
    logic [1:0]    r_start, n_start;

    // output registers
    logic          r_ovalid, n_ovalid;
    logic [7:0]    r_obyte, n_obyte;
    logic [1:0]    r_okind, n_okind;
    logic [5:0]    r_oidx, n_oidx;
    logic          r_oerr, n_oerr;
    logic          r_olast, n_olast;

    // frame store
    logic [7:0]    mem [xfpp_pkg::STORE_DEPTH];
    logic [7:0]    r_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [7:0]    w_wdata;

    logic [FW:0]   w_total;
    logic [FW:0]   w_fill_inc;
    logic [FW:0]   w_sum;
    logic [FW:0]   w_eaddr;
    logic [FW-1:0] w_shaddr;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_bad, r_good, r_oidx, r_obyte};
    assign m_axis_tuser  = {r_oerr, r_okind};
    assign m_axis_tlast  = r_olast;

    // address arithmetic for the store walk
    assign w_fill_inc = {1'b0, r_fill} + (FW+1)'(1);
    assign w_total    = (FW+1)'(r_exp) + (r_il ? (FW+1)'(3) : (FW+1)'(2));
    assign w_sum      = (FW+1)'(r_start) + {1'b0, r_idx};
    assign w_eaddr    = (w_sum >= (FW+1)'(xfpp_pkg::STORE_DEPTH))
                        ? w_sum - (FW+1)'(xfpp_pkg::STORE_DEPTH) : w_sum;
    assign w_shaddr   = FW'(r_pos) + r_idx;

    // store read address selection
    always_comb begin
        case (r_state)
            S_SH_RD: w_raddr = w_shaddr[AW-1:0];
            S_EM_RD: w_raddr = w_eaddr[AW-1:0];
            default: w_raddr = r_idx[AW-1:0];
        endcase
    end

    // store write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_fill[AW-1:0];
        w_wdata = r_byte;
        if (r_state == S_PROC) begin
            if (r_phase == xfpp_pkg::PH_HEADER) begin
                w_we    = (r_byte == r_hdr);
                w_waddr = '0;
            end else begin
                w_we    = 1'b1;
            end
        end else if (r_state == S_SH_WR) begin
            w_we    = 1'b1;
            w_waddr = r_idx[AW-1:0];
            w_wdata = r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_fill   = r_fill;
        n_exp    = r_exp;
        n_kind   = r_kind;
        n_good   = r_good;
        n_bad    = r_bad;
        n_byte   = r_byte;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_keep   = r_keep;
        n_id     = r_id;
        n_xor    = r_xor;
        n_hok    = r_hok;
        n_ret    = r_ret;
        n_n      = r_n;
        n_start  = r_start;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_okind  = r_okind;
        n_oidx   = r_oidx;
        n_oerr   = r_oerr;
        n_olast  = r_olast;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_byte = s_axis_tdata;
                    if (r_fill >= FW'(xfpp_pkg::STORE_DEPTH)) begin
                        n_ret   = 1'b0;
                        n_idx   = FW'(1);
                        n_state = S_RS_RD;
                    end else begin
                        n_state = S_PROC;
                    end
                end
            end
            S_PROC: begin
                n_state = S_IDLE;
                if (r_phase == xfpp_pkg::PH_HEADER) begin
                    if (r_byte == r_hdr) begin
                        n_fill = FW'(1);
                        if (r_il) begin
                            n_phase = xfpp_pkg::PH_ID;
                        end else begin
                            n_exp   = r_imu;
                            n_phase = xfpp_pkg::PH_COLLECT;
                        end
                    end
                end else begin
                    n_fill = w_fill_inc[FW-1:0];
                    if (r_phase == xfpp_pkg::PH_ID) begin
                        case (r_byte)
                            8'd0: begin
                                n_exp = r_imu;  n_kind = xfpp_pkg::KIND_IMU;
                                n_phase = xfpp_pkg::PH_COLLECT;
                            end
                            8'd1: begin
                                n_exp = r_ahrs; n_kind = xfpp_pkg::KIND_AHRS;
                                n_phase = xfpp_pkg::PH_COLLECT;
                            end
                            8'd2: begin
                                n_exp = r_ins;  n_kind = xfpp_pkg::KIND_INS;
                                n_phase = xfpp_pkg::PH_COLLECT;
                            end
                            default: begin
                                n_bad   = r_bad + 32'd1;
                                n_ret   = 1'b1;
                                n_idx   = FW'(1);
                                n_state = S_RS_RD;
                            end
                        endcase
                    end else if (w_fill_inc >= w_total) begin
                        n_idx   = '0;
                        n_xor   = '0;
                        n_hok   = 1'b0;
                        n_state = S_CK_RD;
                    end
                end
            end
            // resync: search for a later header byte
            S_RS_RD: begin
                if (r_idx >= r_fill) begin
                    n_phase = xfpp_pkg::PH_HEADER;
                    n_fill  = '0;
                    n_exp   = '0;
                    n_kind  = xfpp_pkg::KIND_UNKNOWN;
                    n_state = S_RS_RET;
                end else begin
                    n_state = S_RS_CMP;
                end
            end
            S_RS_CMP: begin
                if (r_rdata == r_hdr) begin
                    n_pos   = r_idx[AW-1:0];
                    n_keep  = r_fill - r_idx;
                    n_idx   = '0;
                    n_state = S_SH_RD;
                end else begin
                    n_idx   = r_idx + FW'(1);
                    n_state = S_RS_RD;
                end
            end
            // resync: shift the tail down to the start of the store
            S_SH_RD: begin
                n_state = (r_idx == r_keep) ? S_RS_END : S_SH_WR;
            end
            S_SH_WR: begin
                if (r_idx == FW'(1)) begin
                    n_id = r_rdata;
                end
                n_idx   = r_idx + FW'(1);
                n_state = S_SH_RD;
            end
            S_RS_END: begin
                n_fill  = r_keep;
                n_state = S_RS_RET;
                if (r_il) begin
                    if (r_keep >= FW'(2)) begin
                        n_phase = xfpp_pkg::PH_COLLECT;
                        case (r_id)
                            8'd0: begin n_exp = r_imu;  n_kind = xfpp_pkg::KIND_IMU;  end
                            8'd1: begin n_exp = r_ahrs; n_kind = xfpp_pkg::KIND_AHRS; end
                            8'd2: begin n_exp = r_ins;  n_kind = xfpp_pkg::KIND_INS;  end
                            default: begin
                                n_phase = xfpp_pkg::PH_HEADER;
                                n_fill  = '0;
                                n_exp   = '0;
                                n_kind  = xfpp_pkg::KIND_UNKNOWN;
                            end
                        endcase
                    end else begin
                        n_phase = xfpp_pkg::PH_ID;
                    end
                end else begin
                    n_exp   = r_imu;
                    n_phase = xfpp_pkg::PH_COLLECT;
                end
            end
            // resync done: continue the byte or report the error
            S_RS_RET: begin
                if (r_ret) begin
                    n_obyte  = '0;
                    n_okind  = xfpp_pkg::KIND_IMU;
                    n_oidx   = '0;
                    n_oerr   = 1'b1;
                    n_olast  = 1'b1;
                    n_ovalid = 1'b1;
                    n_state  = S_ER_WT;
                end else begin
                    n_state  = S_PROC;
                end
            end
            // checksum walk over header and body
            S_CK_RD: begin
                n_state = (r_idx == r_fill - FW'(1)) ? S_CK_END : S_CK_ACC;
            end
            S_CK_ACC: begin
                if (r_idx == '0) begin
                    n_hok = (r_rdata == r_hdr);
                end else begin
                    n_xor = r_xor ^ r_rdata;
                end
                n_idx   = r_idx + FW'(1);
                n_state = S_CK_RD;
            end
            S_CK_END: begin
                if (r_hok && (r_xor == r_byte)) begin
                    n_good  = r_good + 32'd1;
                    n_start = r_il ? 2'd2 : 2'd1;
                    n_okind = r_il ? r_kind : xfpp_pkg::KIND_IMU;
                    n_n     = (r_exp > 6'(xfpp_pkg::MAX_RUN))
                              ? 6'(xfpp_pkg::MAX_RUN) : r_exp;
                    if (r_il && (r_kind == xfpp_pkg::KIND_UNKNOWN)) begin
                        n_n = '0;
                    end
                    n_oerr  = 1'b0;
                    n_idx   = '0;
                    n_phase = xfpp_pkg::PH_HEADER;
                    n_fill  = '0;
                    n_exp   = '0;
                    n_kind  = xfpp_pkg::KIND_UNKNOWN;
                    n_state = (n_n == '0) ? S_IDLE : S_EM_RD;
                end else begin
                    n_bad   = r_bad + 32'd1;
                    n_ret   = 1'b1;
                    n_idx   = FW'(1);
                    n_state = S_RS_RD;
                end
            end
            // payload emission, one store read per item
            S_EM_RD: begin
                n_state = S_EM_LD;
            end
            S_EM_LD: begin
                n_obyte  = r_rdata;
                n_oidx   = r_idx[5:0];
                n_olast  = (r_idx + FW'(1) == FW'(r_n));
                n_ovalid = 1'b1;
                n_state  = S_EM_WT;
            end
            S_EM_WT: begin
                if (m_axis_tready) begin
                    n_ovalid = 1'b0;
                    n_idx    = r_idx + FW'(1);
                    n_state  = r_olast ? S_IDLE : S_EM_RD;
                end
            end
            S_ER_WT: begin
                if (m_axis_tready) begin
                    n_ovalid = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= xfpp_pkg::PH_HEADER;
            r_fill   <= '0;
            r_exp    <= '0;
            r_kind   <= xfpp_pkg::KIND_UNKNOWN;
            r_good   <= '0;
            r_bad    <= '0;
            r_ovalid <= 1'b0;
            r_ret    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_fill   <= n_fill;
            r_exp    <= n_exp;
            r_kind   <= n_kind;
            r_good   <= n_good;
            r_bad    <= n_bad;
            r_ovalid <= n_ovalid;
            r_ret    <= n_ret;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_idx   <= n_idx;
        r_pos   <= n_pos;
        r_keep  <= n_keep;
        r_id    <= n_id;
        r_xor   <= n_xor;
        r_hok   <= n_hok;
        r_n     <= n_n;
        r_start <= n_start;
        r_obyte <= n_obyte;
        r_okind <= n_okind;
        r_oidx  <= n_oidx;
        r_oerr  <= n_oerr;
        r_olast <= n_olast;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr  <= 8'd0;
            r_il   <= 1'b1;
            r_imu  <= 6'd36;
            r_ahrs <= 6'd16;
            r_ins  <= 6'd50;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                xfpp_pkg::REG_HEADER: r_hdr  <= i_cfg_data;
                xfpp_pkg::REG_MODE:   r_il   <= i_cfg_data[0];
                xfpp_pkg::REG_IMU:    r_imu  <= i_cfg_data[5:0];
                xfpp_pkg::REG_AHRS:   r_ahrs <= i_cfg_data[5:0];
                xfpp_pkg::REG_INS:    r_ins  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(xfpp_pkg::STORE_DEPTH))
        else $error("fill count beyond store depth");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while a result is pending");

    a_err_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tlast && m_axis_tdata[7:0] == 8'd0))
        else $error("malformed error item");

    a_ovf_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && r_fill == FW'(xfpp_pkg::STORE_DEPTH))
        |=> (r_state == S_RS_RD))
        else $error("full store not resynced before use");

endmodule
